// File: sv/obit_pkg.sv
package obit_pkg;

    localparam int PRICE_W = 32;
    localparam int CNT_W   = 16;
    localparam int AMT_W   = 48;
    localparam int MAG_W   = 47;
    localparam int SIZE_W  = 31;
    localparam int USD_W   = 64;

    localparam logic [1:0] CFG_TRADE_SIZE    = 2'd0;
    localparam logic [1:0] CFG_PROFIT_TARGET = 2'd1;
    localparam logic [1:0] CFG_LOSS_LIMIT    = 2'd2;

    localparam logic [SIZE_W-1:0]         RST_TRADE_SIZE = 31'd1000000;
    localparam logic [PRICE_W-1:0]        RST_PROFIT     = 32'd90;
    localparam logic [PRICE_W-1:0]        RST_LOSS       = 32'd60;
    localparam logic signed [USD_W-1:0]   RST_USD        = 64'sd100000000000000;
    localparam logic signed [AMT_W-1:0]   RST_BTC        = 48'sd50000000;

    localparam logic [1:0] ACT_NONE = 2'd0;
    localparam logic [1:0] ACT_BUY  = 2'd1;
    localparam logic [1:0] ACT_SELL = 2'd2;

    typedef enum logic [1:0] {
        OP_CLEAR,
        OP_BID,
        OP_ASK
    } t_op;

    typedef struct packed {
        logic [PRICE_W-1:0]       price;
        logic [CNT_W-1:0]         order_count;
        logic signed [AMT_W-1:0]  amount;
        logic                     evaluate;
    } t_item;

    typedef struct packed {
        logic [PRICE_W-1:0]       top_bid;
        logic [PRICE_W-1:0]       top_ask;
        logic                     book_ready;
        logic [1:0]               action;
        logic [6:0]               closed_count;
        logic signed [USD_W-1:0]  usd_balance;
        logic signed [AMT_W-1:0]  btc_balance;
        logic [31:0]              total_closed;
        logic [31:0]              wins;
        logic [31:0]              losses;
        logic [6:0]               open_trades;
        logic                     book_full;
    } t_result;

    typedef struct packed {
        t_op                op;
        logic [PRICE_W-1:0] price;
        logic [MAG_W-1:0]   mag;
        logic               evaluate;
    } t_cmd;

    typedef struct packed {
        logic [SIZE_W-1:0]  trade_size;
        logic [PRICE_W-1:0] profit_target;
        logic [PRICE_W-1:0] loss_limit;
    } t_cfg;

endpackage

// File: sv/obit_stream.sv
interface obit_stream #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

// File: sv/obit_ram.sv
module obit_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    i_clk,
    i_we,
    i_waddr,
    i_wdata,
    i_raddr,
    o_rdata
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    input  logic             i_clk;
    input  logic             i_we;
    input  logic [AW-1:0]    i_waddr;
    input  logic [WIDTH-1:0] i_wdata;
    input  logic [AW-1:0]    i_raddr;
    output logic [WIDTH-1:0] o_rdata;

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: sv/obit_front.sv
module obit_front (
    input logic  i_clk,
    input logic  i_rst_n,
    obit_stream.sink   i_item,
    obit_stream.source o_cmd
);
    import obit_pkg::*;

    obit_pkg::t_cmd   n_cmd;
    obit_pkg::t_cmd   r_q [2];
    logic             r_wp, r_rp;
    logic [1:0]       r_cnt;
    logic signed [AMT_W-1:0] neg;
    logic             push, pop;

    always_comb begin
        neg = -i_item.data.amount;
        n_cmd.price    = i_item.data.price;
        n_cmd.evaluate = i_item.data.evaluate;
        if (i_item.data.order_count == '0) begin
            n_cmd.op  = OP_CLEAR;
            n_cmd.mag = '0;
        end else if (i_item.data.amount > 0) begin
            n_cmd.op  = OP_BID;
            n_cmd.mag = i_item.data.amount[MAG_W-1:0];
        end else begin
            n_cmd.op  = OP_ASK;
            n_cmd.mag = neg[AMT_W-1] ? '1 : neg[MAG_W-1:0];
        end
    end

    assign i_item.ready = (r_cnt != 2'd2);
    assign o_cmd.valid  = (r_cnt != 2'd0);
    assign o_cmd.data   = r_q[r_rp];
    assign push = i_item.valid && i_item.ready;
    assign pop  = o_cmd.valid && o_cmd.ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= n_cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

// File: sv/obit_back.sv
module obit_back #(
    parameter int BOOK_LEVELS = 64,
    parameter int MAX_TRADES  = 100
) (
    input logic  i_clk,
    input logic  i_rst_n,
    input obit_pkg::t_cfg i_cfg,
    obit_stream.sink   i_cmd,
    obit_stream.source o_result
);
    import obit_pkg::*;

    localparam int LIW = (BOOK_LEVELS > 1) ? $clog2(BOOK_LEVELS) : 1;
    localparam int LCW = $clog2(BOOK_LEVELS + 1);
    localparam int TIW = (MAX_TRADES > 1) ? $clog2(MAX_TRADES) : 1;
    localparam int TCW = $clog2(MAX_TRADES + 1);
    localparam int LDW = PRICE_W + MAG_W;
    localparam int TDW = PRICE_W + 1;

    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_UPD   = 14'b00000000000010,
        S_APPLY = 14'b00000000000100,
        S_BEST  = 14'b00000000001000,
        S_TRD   = 14'b00000000010000,
        S_TCHK  = 14'b00000000100000,
        S_TMUL  = 14'b00000001000000,
        S_TACC  = 14'b00000010000000,
        S_CRD   = 14'b00000100000000,
        S_CWR   = 14'b00001000000000,
        S_OM1   = 14'b00010000000000,
        S_OM2   = 14'b00100000000000,
        S_OM3   = 14'b01000000000000,
        S_FIN   = 14'b10000000000000
    } t_state;

    function automatic logic signed [USD_W-1:0] usd_sat(input logic signed [USD_W:0] s);
        if (s[USD_W] != s[USD_W-1]) begin
            return s[USD_W] ? {1'b1, {(USD_W-1){1'b0}}} : {1'b0, {(USD_W-1){1'b1}}};
        end
        return s[USD_W-1:0];
    endfunction

    function automatic logic signed [AMT_W-1:0] btc_sat(input logic signed [AMT_W:0] s);
        if (s[AMT_W] != s[AMT_W-1]) begin
            return s[AMT_W] ? {1'b1, {(AMT_W-1){1'b0}}} : {1'b0, {(AMT_W-1){1'b1}}};
        end
        return s[AMT_W-1:0];
    endfunction

    function automatic logic [62:0] px_size(input logic [PRICE_W-1:0] p,
                                            input logic [SIZE_W-1:0] s);
        return {{(63-PRICE_W){1'b0}}, p} * {{(63-SIZE_W){1'b0}}, s};
    endfunction

    t_state r_state, n_state;
    t_cmd   r_cmd, n_cmd;
    logic [LCW-1:0] r_idx, n_idx;
    logic           r_rv, n_rv;
    logic [LIW-1:0] r_ridx, n_ridx;
    logic [BOOK_LEVELS-1:0] r_bval, n_bval, r_aval, n_aval;
    logic           r_hit_f, n_hit_f, r_free_f, n_free_f;
    logic [LIW-1:0] r_hit, n_hit, r_free, n_free;
    logic           r_hb, n_hb, r_ha, n_ha;
    logic [PRICE_W-1:0] r_bb, n_bb, r_ba, n_ba, r_x, n_x;
    logic [MAG_W-1:0]   r_vb, n_vb, r_va, n_va;
    logic [TCW-1:0] r_ntr, n_ntr, r_j, n_j, r_w, n_w, r_ccnt, n_ccnt;
    logic [TIW-1:0] r_t, n_t;
    logic [MAX_TRADES-1:0] r_cl, n_cl;
    logic           r_close, n_close, r_win, n_win, r_sell, n_sell;
    logic [62:0]    r_prod, n_prod;
    logic signed [USD_W-1:0] r_usd, n_usd;
    logic signed [AMT_W-1:0] r_btc, n_btc;
    logic [31:0]    r_tot, n_tot, r_wins, n_wins, r_loss, n_loss;
    logic [1:0]     r_act, n_act;
    logic           r_full, n_full;
    logic           r_ovalid, n_ovalid;
    t_result        r_res, n_res;

    logic           lv_bwe, lv_awe;
    logic [LIW-1:0] lv_waddr;
    logic [LDW-1:0] lv_wdata, lv_brd, lv_ard;
    logic           tr_we;
    logic [TIW-1:0] tr_waddr, tr_raddr;
    logic [TDW-1:0] tr_wdata, tr_rd;

    logic [PRICE_W-1:0] bp, ap, tp, cur;
    logic [MAG_W-1:0]   bamt, aamt;
    logic signed [PRICE_W+1:0] pnl;
    logic [MAG_W+2:0]   vb7, va7;
    logic signed [AMT_W-1:0] size_s;
    logic signed [USD_W-1:0] prod_s;
    logic           scan_done;

    obit_ram #(.WIDTH(LDW), .DEPTH(BOOK_LEVELS)) u_bid_ram (
        .i_clk(i_clk), .i_we(lv_bwe), .i_waddr(lv_waddr), .i_wdata(lv_wdata),
        .i_raddr(r_idx[LIW-1:0]), .o_rdata(lv_brd)
    );
    obit_ram #(.WIDTH(LDW), .DEPTH(BOOK_LEVELS)) u_ask_ram (
        .i_clk(i_clk), .i_we(lv_awe), .i_waddr(lv_waddr), .i_wdata(lv_wdata),
        .i_raddr(r_idx[LIW-1:0]), .o_rdata(lv_ard)
    );
    obit_ram #(.WIDTH(TDW), .DEPTH(MAX_TRADES)) u_trade_ram (
        .i_clk(i_clk), .i_we(tr_we), .i_waddr(tr_waddr), .i_wdata(tr_wdata),
        .i_raddr(tr_raddr), .o_rdata(tr_rd)
    );

    assign i_cmd.ready    = (r_state == S_IDLE);
    assign o_result.valid = r_ovalid;
    assign o_result.data  = r_res;

    assign bp     = lv_brd[LDW-1:MAG_W];
    assign bamt   = lv_brd[MAG_W-1:0];
    assign ap     = lv_ard[LDW-1:MAG_W];
    assign aamt   = lv_ard[MAG_W-1:0];
    assign tp     = tr_rd[TDW-1:1];
    assign cur    = tr_rd[0] ? r_bb : r_ba;
    assign size_s = $signed({{(AMT_W-SIZE_W){1'b0}}, i_cfg.trade_size});
    assign prod_s = $signed({1'b0, r_prod});
    assign vb7    = ({3'b0, r_vb} << 3) - {3'b0, r_vb};
    assign va7    = ({3'b0, r_va} << 3) - {3'b0, r_va};
    assign scan_done = r_rv && (r_ridx == LIW'(BOOK_LEVELS - 1));

    always_comb begin
        pnl = $signed({2'b0, cur}) - $signed({2'b0, tp});
        if (tr_rd[0]) pnl = -pnl;
    end

    always_comb begin
        n_state = r_state;  n_cmd = r_cmd;    n_idx = r_idx;   n_rv = 1'b0;
        n_ridx = r_idx[LIW-1:0];
        n_bval = r_bval;    n_aval = r_aval;  n_hit_f = r_hit_f; n_hit = r_hit;
        n_free_f = r_free_f; n_free = r_free; n_hb = r_hb;     n_ha = r_ha;
        n_bb = r_bb;  n_ba = r_ba;  n_vb = r_vb;  n_va = r_va;  n_x = r_x;
        n_ntr = r_ntr; n_j = r_j; n_w = r_w; n_ccnt = r_ccnt; n_t = r_t; n_cl = r_cl;
        n_close = r_close; n_win = r_win; n_sell = r_sell; n_prod = r_prod;
        n_usd = r_usd; n_btc = r_btc; n_tot = r_tot; n_wins = r_wins; n_loss = r_loss;
        n_act = r_act; n_full = r_full; n_res = r_res;
        n_ovalid = r_ovalid && !o_result.ready;
        lv_bwe = 1'b0; lv_awe = 1'b0;
        lv_waddr = r_hit_f ? r_hit : r_free;
        lv_wdata = {r_cmd.price, r_cmd.mag};
        tr_we = 1'b0; tr_waddr = r_w[TIW-1:0]; tr_wdata = tr_rd; tr_raddr = r_t;

        case (r_state)
            S_IDLE: begin
                if (i_cmd.valid) begin
                    n_cmd = i_cmd.data;
                    n_idx = '0;
                    n_hit_f = 1'b0; n_free_f = 1'b0;
                    n_hb = 1'b0; n_ha = 1'b0; n_bb = '0; n_ba = '0; n_vb = '0; n_va = '0;
                    n_ccnt = '0; n_act = ACT_NONE; n_full = 1'b0;
                    n_state = S_UPD;
                end
            end
            S_UPD, S_BEST: begin
                if (r_idx < LCW'(BOOK_LEVELS)) begin
                    n_rv = 1'b1;
                    n_idx = r_idx + 1'b1;
                end
                if (r_rv) begin
                    if (r_state == S_UPD) begin
                        case (r_cmd.op)
                            OP_CLEAR: begin
                                if (r_bval[r_ridx] && bp == r_cmd.price) n_bval[r_ridx] = 1'b0;
                                if (r_aval[r_ridx] && ap == r_cmd.price) n_aval[r_ridx] = 1'b0;
                            end
                            OP_BID: begin
                                if (r_bval[r_ridx] && bp == r_cmd.price && !r_hit_f) begin
                                    n_hit_f = 1'b1; n_hit = r_ridx;
                                end
                                if (!r_bval[r_ridx] && !r_free_f) begin
                                    n_free_f = 1'b1; n_free = r_ridx;
                                end
                            end
                            OP_ASK: begin
                                if (r_aval[r_ridx] && ap == r_cmd.price && !r_hit_f) begin
                                    n_hit_f = 1'b1; n_hit = r_ridx;
                                end
                                if (!r_aval[r_ridx] && !r_free_f) begin
                                    n_free_f = 1'b1; n_free = r_ridx;
                                end
                            end
                            default: ;
                        endcase
                        if (scan_done) n_state = S_APPLY;
                    end else begin
                        if (r_bval[r_ridx] && (!r_hb || bp > r_bb)) begin
                            n_hb = 1'b1; n_bb = bp; n_vb = bamt;
                        end
                        if (r_aval[r_ridx] && (!r_ha || ap < r_ba)) begin
                            n_ha = 1'b1; n_ba = ap; n_va = aamt;
                        end
                        if (scan_done) begin
                            n_cl = '0;
                            if (!(r_cmd.evaluate && n_hb && n_ha)) begin
                                n_state = S_FIN;
                            end else if (r_ntr == '0) begin
                                n_state = S_OM1;
                            end else begin
                                n_t = TIW'(r_ntr - 1'b1);
                                n_state = S_TRD;
                            end
                        end
                    end
                end
            end
            S_APPLY: begin
                if (r_cmd.op != OP_CLEAR) begin
                    if (r_hit_f || r_free_f) begin
                        lv_bwe = (r_cmd.op == OP_BID);
                        lv_awe = (r_cmd.op == OP_ASK);
                        if (r_cmd.op == OP_BID) n_bval[lv_waddr] = 1'b1;
                        else n_aval[lv_waddr] = 1'b1;
                    end else begin
                        n_full = 1'b1;
                    end
                end
                n_idx = '0;
                n_state = S_BEST;
            end
            S_TRD: begin
                tr_raddr = r_t;
                n_state = S_TCHK;
            end
            S_TCHK: begin
                n_x = cur;
                n_sell = tr_rd[0];
                n_close = (pnl >= $signed({2'b0, i_cfg.profit_target}))
                       || (pnl <= -$signed({2'b0, i_cfg.loss_limit}));
                n_win = (pnl > 0);
                n_cl[r_t] = n_close;
                n_state = S_TMUL;
            end
            S_TMUL: begin
                n_prod = px_size(r_x, i_cfg.trade_size);
                n_state = S_TACC;
            end
            S_TACC: begin
                if (r_close) begin
                    if (r_sell) begin
                        n_usd = usd_sat({r_usd[USD_W-1], r_usd} - {prod_s[USD_W-1], prod_s});
                        n_btc = btc_sat({r_btc[AMT_W-1], r_btc} + {size_s[AMT_W-1], size_s});
                    end else begin
                        n_usd = usd_sat({r_usd[USD_W-1], r_usd} + {prod_s[USD_W-1], prod_s});
                        n_btc = btc_sat({r_btc[AMT_W-1], r_btc} - {size_s[AMT_W-1], size_s});
                    end
                    n_tot = r_tot + 1'b1;
                    if (r_win) n_wins = r_wins + 1'b1;
                    else n_loss = r_loss + 1'b1;
                    n_ccnt = r_ccnt + 1'b1;
                end
                if (r_t == '0) begin
                    n_j = '0; n_w = '0;
                    n_state = S_CRD;
                end else begin
                    n_t = r_t - 1'b1;
                    n_state = S_TRD;
                end
            end
            S_CRD: begin
                tr_raddr = r_j[TIW-1:0];
                if (r_j == r_ntr) begin
                    n_ntr = r_w;
                    n_state = S_OM1;
                end else begin
                    n_state = S_CWR;
                end
            end
            S_CWR: begin
                if (!r_cl[r_j[TIW-1:0]]) begin
                    tr_we = 1'b1;
                    n_w = r_w + 1'b1;
                end
                n_j = r_j + 1'b1;
                n_state = S_CRD;
            end
            S_OM1: begin
                n_prod = px_size(r_bb, i_cfg.trade_size);
                n_state = S_OM2;
            end
            S_OM2: begin
                tr_waddr = r_ntr[TIW-1:0];
                tr_wdata = {r_bb, 1'b0};
                if (r_ntr < TCW'(MAX_TRADES) && {3'b0, r_vb} > va7 && r_usd >= prod_s) begin
                    tr_we = 1'b1;
                    n_usd = r_usd - prod_s;
                    n_btc = btc_sat({r_btc[AMT_W-1], r_btc} + {size_s[AMT_W-1], size_s});
                    n_ntr = r_ntr + 1'b1;
                    n_act = ACT_BUY;
                    n_state = S_FIN;
                end else begin
                    n_prod = px_size(r_ba, i_cfg.trade_size);
                    n_state = S_OM3;
                end
            end
            S_OM3: begin
                tr_waddr = r_ntr[TIW-1:0];
                tr_wdata = {r_ba, 1'b1};
                if (r_ntr < TCW'(MAX_TRADES) && {3'b0, r_va} > vb7 && r_btc >= size_s) begin
                    tr_we = 1'b1;
                    n_usd = usd_sat({r_usd[USD_W-1], r_usd} + {prod_s[USD_W-1], prod_s});
                    n_btc = r_btc - size_s;
                    n_ntr = r_ntr + 1'b1;
                    n_act = ACT_SELL;
                end
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!r_ovalid || o_result.ready) begin
                    n_res.top_bid      = r_bb;
                    n_res.top_ask      = r_ba;
                    n_res.book_ready   = r_hb && r_ha;
                    n_res.action       = r_act;
                    n_res.closed_count = 7'(r_ccnt);
                    n_res.usd_balance  = r_usd;
                    n_res.btc_balance  = r_btc;
                    n_res.total_closed = r_tot;
                    n_res.wins         = r_wins;
                    n_res.losses       = r_loss;
                    n_res.open_trades  = 7'(r_ntr);
                    n_res.book_full    = r_full;
                    n_ovalid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;   r_idx <= n_idx;   r_rv <= n_rv;   r_ridx <= n_ridx;
        r_hit_f <= n_hit_f; r_hit <= n_hit; r_free_f <= n_free_f; r_free <= n_free;
        r_hb <= n_hb; r_ha <= n_ha; r_bb <= n_bb; r_ba <= n_ba; r_vb <= n_vb; r_va <= n_va;
        r_x <= n_x; r_j <= n_j; r_w <= n_w; r_ccnt <= n_ccnt; r_t <= n_t; r_cl <= n_cl;
        r_close <= n_close; r_win <= n_win; r_sell <= n_sell; r_prod <= n_prod;
        r_act <= n_act; r_full <= n_full; r_res <= n_res;
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_bval   <= '0;
            r_aval   <= '0;
            r_ntr    <= '0;
            r_usd    <= RST_USD;
            r_btc    <= RST_BTC;
            r_tot    <= '0;
            r_wins   <= '0;
            r_loss   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_bval   <= n_bval;
            r_aval   <= n_aval;
            r_ntr    <= n_ntr;
            r_usd    <= n_usd;
            r_btc    <= n_btc;
            r_tot    <= n_tot;
            r_wins   <= n_wins;
            r_loss   <= n_loss;
            r_ovalid <= n_ovalid;
        end
    end
endmodule

// File: sv/order_book_imbalance_trader.sv
// Channel    Dir  Handshake                  Payload
// i_item     in   i_item.valid/ready         price, order_count, amount, evaluate
// o_result   out  o_result.valid/ready       top_bid ... book_full
// i_cfg_*    in   i_cfg_we                   i_cfg_idx selects register, i_cfg_data
//
// An update scans the level memories twice: once to apply it and once to find the best bid
// and ask. With evaluation, each open trade then gets a close check (S_TRD to S_TACC) and a
// compaction step (S_CRD, S_CWR) before the order decision (S_OM1 to S_OM3).
// A two-entry queue takes updates while the sequencer is busy; a full output register
// stalls the sequencer at its last step. Synchronous active-low reset empties the book
// and the trade list at once and restores balances and registers.
module order_book_imbalance_trader #(
    parameter int BOOK_LEVELS = 64,
    parameter int MAX_TRADES  = 100
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    obit_stream.sink    i_item,
    obit_stream.source  o_result,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);
    import obit_pkg::*;

    t_cfg r_cfg;

    obit_stream #(.T(t_cmd)) cmd_q ();

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.trade_size    <= RST_TRADE_SIZE;
            r_cfg.profit_target <= RST_PROFIT;
            r_cfg.loss_limit    <= RST_LOSS;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TRADE_SIZE:    r_cfg.trade_size    <= i_cfg_data[SIZE_W-1:0];
                CFG_PROFIT_TARGET: r_cfg.profit_target <= i_cfg_data;
                CFG_LOSS_LIMIT:    r_cfg.loss_limit    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    obit_front u_front (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_item(i_item),
        .o_cmd(cmd_q.source)
    );

    obit_back #(.BOOK_LEVELS(BOOK_LEVELS), .MAX_TRADES(MAX_TRADES)) u_back (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg(r_cfg),
        .i_cmd(cmd_q.sink),
        .o_result(o_result)
    );
endmodule

// File: test/tb_order_book_imbalance_trader.sv
`timescale 1ns / 100ps

module tb_order_book_imbalance_trader;
    import obit_pkg::*;

    localparam int LEVELS = 64;
    localparam int TRADES = 100;
    localparam int DRAIN = 1000;
    localparam longint LIMIT = 20000000;
    localparam longint USD_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint USD_MIN = 64'sh8000_0000_0000_0000;
    localparam longint AMT_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint AMT_MIN = -AMT_MAX - 1;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;

    obit_stream #(.T(t_item))   item_if ();
    obit_stream #(.T(t_result)) result_if ();

    order_book_imbalance_trader dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (item_if.sink),
        .o_result   (result_if.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // book and trade model
    logic [31:0] lvl_px  [2][LEVELS];
    longint      lvl_amt [2][LEVELS];
    bit          lvl_ok  [2][LEVELS];
    logic [31:0] trd_px  [TRADES];
    bit          trd_sell[TRADES];
    int          trd_n;
    longint      usd_cash, btc_coin;
    logic [31:0] n_closed, n_wins, n_losses;
    longint      size_cfg, profit_cfg, loss_cfg;

    t_item   pending[$];
    t_result expected[$];
    int      errors;
    longint  cycles;
    int      idle_pct, stall_pct;
    bit      hold_send;
    bit      took;
    longint  center;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic longint usd_sat(longint a, longint b);
        if (b > 0 && a > USD_MAX - b) return USD_MAX;
        if (b < 0 && a < USD_MIN - b) return USD_MIN;
        return a + b;
    endfunction

    function automatic longint btc_sat(longint a, longint b);
        longint r;
        r = a + b;
        if (r > AMT_MAX) return AMT_MAX;
        if (r < AMT_MIN) return AMT_MIN;
        return r;
    endfunction

    function automatic bit book_set(int s, logic [31:0] p, longint a);
        for (int i = 0; i < LEVELS; i++)
            if (lvl_ok[s][i] && lvl_px[s][i] == p) begin
                lvl_amt[s][i] = a;
                return 1'b0;
            end
        for (int i = 0; i < LEVELS; i++)
            if (!lvl_ok[s][i]) begin
                lvl_ok[s][i] = 1'b1;
                lvl_px[s][i] = p;
                lvl_amt[s][i] = a;
                return 1'b0;
            end
        return 1'b1;
    endfunction

    function automatic t_result trade_update(t_item it);
        t_result r;
        longint amt, mag, vb, va, cur, pnl, cost;
        logic [31:0] bb, ba;
        bit hb, ha, full, sell;
        int closed;
        amt = longint'(it.amount);
        full = 1'b0;
        closed = 0;
        hb = 1'b0;
        ha = 1'b0;
        bb = '0;
        ba = '0;
        vb = 0;
        va = 0;
        r = '0;
        r.action = ACT_NONE;
        if (it.order_count != 0) begin
            if (amt > 0) begin
                full = book_set(0, it.price, amt);
            end else begin
                mag = -amt;
                if (mag > AMT_MAX) mag = AMT_MAX;
                full = book_set(1, it.price, mag);
            end
        end else begin
            for (int s = 0; s < 2; s++)
                for (int i = 0; i < LEVELS; i++)
                    if (lvl_ok[s][i] && lvl_px[s][i] == it.price) lvl_ok[s][i] = 1'b0;
        end
        for (int i = 0; i < LEVELS; i++) begin
            if (lvl_ok[0][i] && (!hb || lvl_px[0][i] > bb)) begin
                hb = 1'b1;
                bb = lvl_px[0][i];
                vb = lvl_amt[0][i];
            end
            if (lvl_ok[1][i] && (!ha || lvl_px[1][i] < ba)) begin
                ha = 1'b1;
                ba = lvl_px[1][i];
                va = lvl_amt[1][i];
            end
        end
        if (it.evaluate && hb && ha) begin
            for (int i = trd_n - 1; i >= 0; i--) begin
                sell = trd_sell[i];
                cur = sell ? longint'(bb) : longint'(ba);
                pnl = cur - longint'(trd_px[i]);
                if (sell) pnl = -pnl;
                if (pnl >= profit_cfg || pnl <= -loss_cfg) begin
                    if (sell) begin
                        usd_cash = usd_sat(usd_cash, -(cur * size_cfg));
                        btc_coin = btc_sat(btc_coin, size_cfg);
                    end else begin
                        usd_cash = usd_sat(usd_cash, cur * size_cfg);
                        btc_coin = btc_sat(btc_coin, -size_cfg);
                    end
                    n_closed++;
                    if (pnl > 0) n_wins++;
                    else n_losses++;
                    for (int k = i; k + 1 < trd_n; k++) begin
                        trd_px[k] = trd_px[k + 1];
                        trd_sell[k] = trd_sell[k + 1];
                    end
                    trd_n--;
                    closed++;
                end
            end
            if (trd_n < TRADES) begin
                cost = longint'(bb) * size_cfg;
                if (vb > 7 * va && usd_cash >= cost) begin
                    usd_cash -= cost;
                    btc_coin = btc_sat(btc_coin, size_cfg);
                    trd_px[trd_n] = bb;
                    trd_sell[trd_n] = 1'b0;
                    trd_n++;
                    r.action = ACT_BUY;
                end else if (va > 7 * vb && btc_coin >= size_cfg) begin
                    usd_cash = usd_sat(usd_cash, longint'(ba) * size_cfg);
                    btc_coin -= size_cfg;
                    trd_px[trd_n] = ba;
                    trd_sell[trd_n] = 1'b1;
                    trd_n++;
                    r.action = ACT_SELL;
                end
            end
        end
        r.top_bid = bb;
        r.top_ask = ba;
        r.book_ready = hb && ha;
        r.closed_count = closed[6:0];
        r.usd_balance = usd_cash;
        r.btc_balance = btc_coin[47:0];
        r.total_closed = n_closed;
        r.wins = n_wins;
        r.losses = n_losses;
        r.open_trades = trd_n[6:0];
        r.book_full = full;
        return r;
    endfunction

    function automatic void field_check(string name, logic [63:0] e, logic [63:0] a);
        if (e !== a) begin
            $error("%s: expected %0h, got %0h", name, e, a);
            errors++;
        end
    endfunction

    // accept side: predict on every input transaction, check every output one
    always @(posedge i_clk) begin
        t_result e, a;
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("** order_book_imbalance_trader: FAILED **");
            $finish;
        end
        if (i_rst_n && item_if.valid && item_if.ready) begin
            expected.insert(expected.size(), trade_update(item_if.data));
            took <= 1'b1;
        end
        if (i_rst_n && result_if.valid && result_if.ready) begin
            a = result_if.data;
            if (expected.size() == 0) begin
                $error("result with no transaction pending");
                errors++;
            end else begin
                e = expected.pop_front();
                field_check("top_bid", e.top_bid, a.top_bid);
                field_check("top_ask", e.top_ask, a.top_ask);
                field_check("book_ready", e.book_ready, a.book_ready);
                field_check("action", e.action, a.action);
                field_check("closed_count", e.closed_count, a.closed_count);
                field_check("usd_balance", e.usd_balance, a.usd_balance);
                field_check("btc_balance", e.btc_balance, a.btc_balance);
                field_check("total_closed", e.total_closed, a.total_closed);
                field_check("wins", e.wins, a.wins);
                field_check("losses", e.losses, a.losses);
                field_check("open_trades", e.open_trades, a.open_trades);
                field_check("book_full", e.book_full, a.book_full);
            end
        end
    end

    always @(negedge i_clk) begin
        if (took || !item_if.valid) begin
            if (i_rst_n && !hold_send && pending.size() != 0
                    && $urandom_range(99) >= idle_pct) begin
                item_if.data <= pending.pop_front();
                item_if.valid <= 1'b1;
            end else begin
                item_if.valid <= 1'b0;
            end
        end
        took <= 1'b0;
        result_if.ready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_TRADE_SIZE: size_cfg = longint'(val & 32'h7FFF_FFFF);
            CFG_PROFIT_TARGET: profit_cfg = longint'(val);
            default: loss_cfg = longint'(val);
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending.size() != 0 || item_if.valid || expected.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN) @(negedge i_clk);
    endtask

    function automatic t_item mk(logic [31:0] p, logic [15:0] c, longint a, bit ev);
        t_item it;
        it.price = p;
        it.order_count = c;
        it.amount = a[47:0];
        it.evaluate = ev;
        return it;
    endfunction

    function automatic longint vol();
        return longint'($urandom_range(1, 1000)) << $urandom_range(0, 20);
    endfunction

    task automatic push_random(int count);
        t_item it;
        longint p;
        int k;
        for (int j = 0; j < count; j++) begin
            k = $urandom_range(99);
            center += longint'($urandom_range(60)) - 30;
            if (center < 1000) center = 1000;
            if (k < 10) begin
                it.price = $urandom;
                it.order_count = 16'($urandom);
                it.amount = 48'({$urandom, $urandom});
                it.evaluate = 1'($urandom);
                pending.insert(pending.size(), it);
                if ($urandom_range(99) < 85)
                    pending.insert(pending.size(), mk(it.price, 16'd0, 0, 1'($urandom)));
            end else if (k < 25) begin
                p = center + longint'($urandom_range(80)) - 40;
                pending.insert(pending.size(), mk(p[31:0], 16'd0, 0, 1'($urandom)));
            end else if (k < 62) begin
                p = center - longint'($urandom_range(40));
                pending.insert(pending.size(),
                               mk(p[31:0], 16'($urandom_range(1, 65535)), vol(),
                                  $urandom_range(99) < 60));
            end else begin
                p = center + longint'($urandom_range(40));
                pending.insert(pending.size(),
                               mk(p[31:0], 16'($urandom_range(1, 65535)), -vol(),
                                  $urandom_range(99) < 60));
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_TRADE_SIZE;
        i_cfg_data = '0;
        item_if.valid = 1'b0;
        item_if.data = '0;
        result_if.ready = 1'b0;
        errors = 0;
        cycles = 0;
        took = 1'b0;
        hold_send = 1'b0;
        idle_pct = 0;
        stall_pct = 0;
        center = 50000;
        for (int s = 0; s < 2; s++)
            for (int i = 0; i < LEVELS; i++) lvl_ok[s][i] = 1'b0;
        trd_n = 0;
        usd_cash = longint'(RST_USD);
        btc_coin = longint'(RST_BTC);
        n_closed = '0;
        n_wins = '0;
        n_losses = '0;
        size_cfg = longint'(RST_TRADE_SIZE);
        profit_cfg = longint'(RST_PROFIT);
        loss_cfg = longint'(RST_LOSS);
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty side, extremes, both sides at one price, imbalance, close
        pending.insert(pending.size(), mk(32'd50000, 16'd1, 1000, 1'b1));
        pending.insert(pending.size(), mk(32'hFFFF_FFFF, 16'hFFFF, AMT_MIN, 1'b1));
        pending.insert(pending.size(), mk(32'hFFFF_FFFF, 16'd0, 0, 1'b1));
        pending.insert(pending.size(), mk(32'd0, 16'd1, AMT_MAX, 1'b0));
        pending.insert(pending.size(), mk(32'd0, 16'd0, 0, 1'b0));
        pending.insert(pending.size(), mk(32'd50100, 16'd3, 0, 1'b1));
        pending.insert(pending.size(), mk(32'd50100, 16'd2, -1000, 1'b1));
        pending.insert(pending.size(), mk(32'd50000, 16'd5, 8000, 1'b0));
        pending.insert(pending.size(), mk(32'd50000, 16'd5, 7001, 1'b1));
        pending.insert(pending.size(), mk(32'd50100, 16'd2, -1000, 1'b1));
        pending.insert(pending.size(), mk(32'd50100, 16'd2, -100, 1'b1));
        pending.insert(pending.size(), mk(32'd50200, 16'd2, -100, 1'b1));
        pending.insert(pending.size(), mk(32'd50150, 16'd2, 1, 1'b1));
        pending.insert(pending.size(), mk(32'd50150, 16'd2, -1, 1'b0));
        pending.insert(pending.size(), mk(32'd50150, 16'd0, 0, 1'b1));
        pending.insert(pending.size(), mk(32'd49900, 16'd4, -1, 1'b1));
        pending.insert(pending.size(), mk(32'd49950, 16'd4, 100000, 1'b1));
        pending.insert(pending.size(), mk(32'd49900, 16'd0, 0, 1'b1));
        pending.insert(pending.size(), mk(32'd1, 16'd1, -(AMT_MAX), 1'b1));
        pending.insert(pending.size(), mk(32'd1, 16'd0, 0, 1'b1));
        // table full on both sides
        for (int i = 0; i < LEVELS + 1; i++)
            pending.insert(pending.size(), mk(32'd40000 + i, 16'd1, 10, 1'b0));
        for (int i = 0; i < LEVELS + 1; i++)
            pending.insert(pending.size(), mk(32'd60000 + i, 16'd1, -10, 1'b0));
        for (int i = 0; i < LEVELS + 1; i++)
            pending.insert(pending.size(), mk(32'd40000 + i, 16'd0, 0, 1'b0));
        for (int i = 0; i < LEVELS + 1; i++)
            pending.insert(pending.size(), mk(32'd60000 + i, 16'd0, 0, 1'b0));
        push_random(200);
        wait_drained();

        cfg_write(CFG_TRADE_SIZE, 32'h7FFF_FFFF);
        cfg_write(CFG_PROFIT_TARGET, 32'd0);
        cfg_write(CFG_LOSS_LIMIT, 32'd0);
        idle_pct = 47;
        push_random(170);
        wait_drained();

        cfg_write(CFG_TRADE_SIZE, 32'd0);
        cfg_write(CFG_PROFIT_TARGET, 32'hFFFF_FFFF);
        cfg_write(CFG_LOSS_LIMIT, 32'hFFFF_FFFF);
        idle_pct = 0;
        stall_pct = 47;
        push_random(200);
        wait_drained();

        cfg_write(CFG_TRADE_SIZE, $urandom_range(1, 5000000));
        cfg_write(CFG_PROFIT_TARGET, $urandom_range(1, 200));
        cfg_write(CFG_LOSS_LIMIT, $urandom_range(1, 200));
        idle_pct = 23;
        stall_pct = 23;
        push_random(150);
        while (pending.size() > 100) @(negedge i_clk);
        hold_send = 1'b1;
        while (item_if.valid || expected.size() != 0) @(negedge i_clk);
        hold_send = 1'b0;
        wait_drained();

        cfg_write(CFG_TRADE_SIZE, 32'hFFFF_FFFF);
        cfg_write(CFG_PROFIT_TARGET, 32'd90);
        cfg_write(CFG_LOSS_LIMIT, 32'd60);
        idle_pct = 0;
        stall_pct = 0;
        cfg_write(CFG_TRADE_SIZE, 32'd1000000);
        push_random(80);
        wait_drained();

        if (errors == 0) begin
            $display("** order_book_imbalance_trader: PASSED **");
        end else begin
            $display("** order_book_imbalance_trader: FAILED **");
        end
        $finish;
    end
endmodule

// File: sim.f
sv/obit_pkg.sv
sv/obit_stream.sv
sv/obit_ram.sv
sv/obit_front.sv
sv/obit_back.sv
sv/order_book_imbalance_trader.sv
test/tb_order_book_imbalance_trader.sv
